>>> src/nbt_pkg.sv
// Package with types, codes and sizing constants for the NAT64 binding table.
`default_nettype none
package nbt_pkg;

  // Table geometry: cells are grouped so that each group resolves its own priority.
  localparam int ENTRIES    = 256;
  localparam int GRP        = 16;
  localparam int NGRP       = ENTRIES / GRP;
  localparam int GRP_CNT_W  = $clog2(GRP + 1);
  localparam int CNT_W      = 9;

  // Request codes.
  localparam logic [2:0] REQ_ADD    = 3'd0;
  localparam logic [2:0] REQ_FIND6  = 3'd1;
  localparam logic [2:0] REQ_FIND4  = 3'd2;
  localparam logic [2:0] REQ_REMOVE = 3'd3;
  localparam logic [2:0] REQ_RANGE  = 3'd4;
  localparam logic [2:0] REQ_FLUSH  = 3'd5;

  // Protocol code that is never stored.
  localparam logic [1:0] PROTO_BAD = 2'd3;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVAL    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_EXISTS   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  proto;
    logic [63:0] v6_addr_hi;
    logic [63:0] v6_addr_lo;
    logic [15:0] v6_port;
    logic [31:0] v4_addr;
    logic [15:0] v4_port;
    logic [5:0]  prefix_len;
    logic [15:0] port_max;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [63:0]      hit_v6_addr_hi;
    logic [63:0]      hit_v6_addr_lo;
    logic [15:0]      hit_v6_port;
    logic [31:0]      hit_v4_addr;
    logic [15:0]      hit_v4_port;
    logic [CNT_W-1:0] proto_count;
  } rsp_t;

  // Per-cell match flags, also used for the priority chain.
  typedef struct packed {
    logic m6;
    logic m4;
    logic free;
  } flags_t;

  // Data a cell drives onto the OR reduction.
  typedef struct packed {
    logic        rm_ok;
    logic [63:0] v6_hi;
    logic [63:0] v6_lo;
    logic [15:0] v6_port;
    logic [31:0] v4_addr;
    logic [15:0] v4_port;
  } hit_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_WRITE,
    CMD_DROP1,
    CMD_DROPRNG,
    CMD_FLUSH
  } cell_cmd_t;

  typedef enum logic [1:0] {
    HS_NONE,
    HS_V6,
    HS_V4
  } hsel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMP,
    S_PRI,
    S_SEL,
    S_OUT1,
    S_OUT2,
    S_ACT,
    S_CNT1,
    S_CNT2,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

>>> src/nbt_cell.sv
// One table entry: storage, key compares and its link in the priority chain.
`default_nettype none
module nbt_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  nbt_pkg::req_t       req,
  input  wire  [31:0]         rng_mask,
  input  nbt_pkg::hsel_t      hsel,
  input  nbt_pkg::cell_cmd_t  cmd,
  input  nbt_pkg::flags_t     grp_lower,
  input  nbt_pkg::flags_t     chain_in,
  output nbt_pkg::flags_t     chain_out,
  output nbt_pkg::hit_t       hit,
  output logic                cnt_bit
);
  import nbt_pkg::*;

  logic        valid_r;
  logic [1:0]  proto_r;
  logic [63:0] v6_hi_r;
  logic [63:0] v6_lo_r;
  logic [15:0] v6_port_r;
  logic [31:0] v4_addr_r;
  logic [15:0] v4_port_r;

  flags_t flags_nxt, flags_r, first_r;
  logic   rng_nxt, rng_r;
  logic   sel;

  // Key compares against the request held at the top level.
  always_comb begin
    flags_nxt.m6 = valid_r && (proto_r == req.proto) && (v6_hi_r == req.v6_addr_hi) &&
                   (v6_lo_r == req.v6_addr_lo) && (v6_port_r == req.v6_port);
    flags_nxt.m4 = valid_r && (proto_r == req.proto) && (v4_addr_r == req.v4_addr) &&
                   (v4_port_r == req.v4_port);
    flags_nxt.free = !valid_r;
    rng_nxt = valid_r && (((v4_addr_r ^ req.v4_addr) & rng_mask) == 32'd0) &&
              (v4_port_r >= req.v4_port) && (v4_port_r <= req.port_max);
  end

  // Match flags and first-match marks are refreshed every cycle.
  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
    rng_r   <= rng_nxt;
    first_r <= flags_r & ~chain_in & ~grp_lower;
  end

  // Pass the "seen a lower match" marks to the next cell.
  assign chain_out = chain_in | flags_r;

  // Payload drives the reduction only from the selected cell; rm_ok is not gated.
  always_comb begin
    unique case (hsel)
      HS_V6:   sel = first_r.m6;
      HS_V4:   sel = first_r.m4;
      default: sel = 1'b0;
    endcase
    hit.rm_ok   = first_r.m4 && flags_r.m6;
    hit.v6_hi   = sel ? v6_hi_r   : 64'd0;
    hit.v6_lo   = sel ? v6_lo_r   : 64'd0;
    hit.v6_port = sel ? v6_port_r : 16'd0;
    hit.v4_addr = sel ? v4_addr_r : 32'd0;
    hit.v4_port = sel ? v4_port_r : 16'd0;
  end

  assign cnt_bit = valid_r && (proto_r == req.proto);

  // Valid bit updates.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_WRITE:   if (first_r.free) valid_r <= 1'b1;
        CMD_DROP1:   if (first_r.m4 && flags_r.m6) valid_r <= 1'b0;
        CMD_DROPRNG: if (rng_r) valid_r <= 1'b0;
        CMD_FLUSH:   valid_r <= 1'b0;
        default:     valid_r <= valid_r;
      endcase
    end
  end

  // Entry payload, written only when this cell is the lowest free one.
  always_ff @(posedge clk) begin
    if ((cmd == CMD_WRITE) && first_r.free) begin
      proto_r   <= req.proto;
      v6_hi_r   <= req.v6_addr_hi;
      v6_lo_r   <= req.v6_addr_lo;
      v6_port_r <= req.v6_port;
      v4_addr_r <= req.v4_addr;
      v4_port_r <= req.v4_port;
    end
  end

endmodule
`default_nettype wire

>>> src/nat64_binding_table.sv
// One request at a time; in_ready is high only while the sequencer is idle, and a request
// then runs through the compare, priority, reduction and population-count steps across
// the row of entry cells before its result beat is registered.
// A result that waits on out_ready holds the sequencer in its last step.
// Reset: synchronous active-low rst_n empties the table and clears all handshake state.
`default_nettype none
module nat64_binding_table (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  nbt_pkg::req_t  in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output nbt_pkg::rsp_t  out_data
);
  import nbt_pkg::*;

  state_t state_r, state_nxt;
  req_t   req_r;
  logic [31:0] rng_mask_r;
  logic [5:0]  plen;

  flags_t chain [NGRP][GRP+1];
  hit_t   cell_hit [NGRP][GRP];
  logic   cell_cnt [NGRP][GRP];
  flags_t grp_any_r [NGRP];
  flags_t grp_lower [NGRP];
  flags_t any_r;
  hit_t   grp_hit_r [NGRP];
  hit_t   glob_hit;
  logic [GRP_CNT_W-1:0] grp_cnt_r [NGRP];
  logic [CNT_W-1:0]     cnt_r;

  hsel_t     hsel;
  cell_cmd_t act_r, act_nxt, cmd;
  logic [2:0] status_r, status_nxt;
  hit_t       hitd_r;
  logic       show_hit;
  logic       p_bad;
  logic       out_valid_r;
  rsp_t       out_data_r;

  // Request capture and the range mask derived from the prefix length.
  assign plen = (in_data.prefix_len > 6'd32) ? 6'd32 : in_data.prefix_len;
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r      <= in_data;
      rng_mask_r <= (plen == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - plen));
    end
  end

  assign cmd = (state_r == S_ACT) ? act_r : CMD_NONE;

  // The row of cells, in groups with a chain inside each group.
  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    assign chain[g][0] = '0;
    for (genvar c = 0; c < GRP; c++) begin : g_cell
      nbt_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_r),
        .rng_mask  (rng_mask_r),
        .hsel      (hsel),
        .cmd       (cmd),
        .grp_lower (grp_lower[g]),
        .chain_in  (chain[g][c]),
        .chain_out (chain[g][c+1]),
        .hit       (cell_hit[g][c]),
        .cnt_bit   (cell_cnt[g][c])
      );
    end
  end

  // Group level: any-match marks, hit reduction and population counts.
  always_ff @(posedge clk) begin
    for (int g = 0; g < NGRP; g++) begin
      hit_t                 h;
      logic [GRP_CNT_W-1:0] n;
      h = '0;
      n = '0;
      for (int c = 0; c < GRP; c++) begin
        h = h | cell_hit[g][c];
        n = n + GRP_CNT_W'(cell_cnt[g][c]);
      end
      grp_any_r[g] <= chain[g][GRP];
      grp_hit_r[g] <= h;
      grp_cnt_r[g] <= n;
    end
  end

  // Prefix of lower groups, global OR and count total.
  always_comb begin
    flags_t acc;
    acc      = '0;
    glob_hit = '0;
    for (int g = 0; g < NGRP; g++) begin
      grp_lower[g] = acc;
      acc          = acc | grp_any_r[g];
      glob_hit     = glob_hit | grp_hit_r[g];
    end
  end

  always_ff @(posedge clk) begin
    flags_t           a;
    logic [CNT_W-1:0] s;
    a = '0;
    s = '0;
    for (int g = 0; g < NGRP; g++) begin
      a = a | grp_any_r[g];
      s = s + CNT_W'(grp_cnt_r[g]);
    end
    any_r <= a;
    cnt_r <= s;
  end

  // Which first match drives the hit reduction.
  always_comb begin
    unique case (req_r.req_type)
      REQ_ADD:    hsel = any_r.m6 ? HS_V6 : (any_r.m4 ? HS_V4 : HS_NONE);
      REQ_FIND6:  hsel = HS_V6;
      REQ_FIND4:  hsel = HS_V4;
      REQ_REMOVE: hsel = HS_V4;
      default:    hsel = HS_NONE;
    endcase
  end

  // Status and table action.
  assign p_bad = (req_r.proto == PROTO_BAD);
  always_comb begin
    status_nxt = ST_OK;
    act_nxt    = CMD_NONE;
    show_hit   = 1'b0;
    unique case (req_r.req_type)
      REQ_ADD: begin
        if (p_bad) status_nxt = ST_INVAL;
        else if (any_r.m6 || any_r.m4) begin
          status_nxt = ST_EXISTS;
          show_hit   = 1'b1;
        end else if (!any_r.free) status_nxt = ST_FULL;
        else act_nxt = CMD_WRITE;
      end
      REQ_FIND6: begin
        if (p_bad) status_nxt = ST_INVAL;
        else if (any_r.m6) show_hit = 1'b1;
        else status_nxt = ST_NOTFOUND;
      end
      REQ_FIND4: begin
        if (p_bad) status_nxt = ST_INVAL;
        else if (any_r.m4) show_hit = 1'b1;
        else status_nxt = ST_NOTFOUND;
      end
      REQ_REMOVE: begin
        if (p_bad) status_nxt = ST_INVAL;
        else if (any_r.m4 && glob_hit.rm_ok) act_nxt = CMD_DROP1;
        else status_nxt = ST_NOTFOUND;
      end
      REQ_RANGE: act_nxt = CMD_DROPRNG;
      REQ_FLUSH: act_nxt = CMD_FLUSH;
      default:   status_nxt = ST_INVAL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= CMD_NONE;
    end else if (state_r == S_OUT2) begin
      act_r <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT2) begin
      status_r <= status_nxt;
      hitd_r   <= show_hit ? glob_hit : '0;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_nxt = S_CMP;
      end
      S_CMP:  state_nxt = S_PRI;
      S_PRI:  state_nxt = S_SEL;
      S_SEL:  state_nxt = S_OUT1;
      S_OUT1: state_nxt = S_OUT2;
      S_OUT2: state_nxt = S_ACT;
      S_ACT:  state_nxt = S_CNT1;
      S_CNT1: state_nxt = S_CNT2;
      S_CNT2: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_data_r.status         <= status_r;
      out_data_r.hit_v6_addr_hi <= hitd_r.v6_hi;
      out_data_r.hit_v6_addr_lo <= hitd_r.v6_lo;
      out_data_r.hit_v6_port    <= hitd_r.v6_port;
      out_data_r.hit_v4_addr    <= hitd_r.v4_addr;
      out_data_r.hit_v4_port    <= hitd_r.v4_port;
      out_data_r.proto_count    <= cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> src/nbt_checker.sv
// Port-level checks for the binding table, bound to the top level.
`default_nettype none
module nbt_checker (
  input wire            clk,
  input wire            rst_n,
  input wire            in_valid,
  input wire            in_ready,
  input wire            out_valid,
  input wire            out_ready,
  input nbt_pkg::rsp_t  out_data
);
  import nbt_pkg::*;

  // A result beat holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed before it was taken");

  // Requests are worked one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in flight");

  // Hit fields are only populated on a found or clashing entry.
  a_hit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) && (out_data.status != ST_EXISTS) |->
    (out_data.hit_v6_addr_hi == 64'd0) && (out_data.hit_v6_addr_lo == 64'd0) &&
    (out_data.hit_v6_port == 16'd0) && (out_data.hit_v4_addr == 32'd0) &&
    (out_data.hit_v4_port == 16'd0))
    else $error("hit fields set on a miss or error");

  // Count never exceeds the table size.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.proto_count <= CNT_W'(ENTRIES)))
    else $error("protocol count above table size");

endmodule

bind nat64_binding_table nbt_checker u_nbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
